### hdl/dphist_pkg.sv
// Shared types and constants for the diphoton cut and mass histogram core.
package dphist_pkg;

	// Histogram geometry.
	localparam int NUM_CLASSES = 12;
	localparam int NUM_BINS    = 80;
	localparam int COUNT_WIDTH = 32;
	localparam int HIST_SIZE   = NUM_CLASSES * (NUM_BINS + 1);
	localparam int ADDR_W      = $clog2(HIST_SIZE);

	// Fixed field widths of a result item.
	localparam int CLASS_W = 4;
	localparam int BIN_W   = 7;
	localparam logic [CLASS_W-1:0] NO_CLASS = 4'd12;

	// Stream widths, padded to whole bytes.
	localparam int IN_W      = 168;
	localparam int OUT_BITS  = 1 + CLASS_W + BIN_W + COUNT_WIDTH;
	localparam int OUT_W     = ((OUT_BITS + 7) / 8) * 8;

	// Configuration port.
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_SEP  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_IMB  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_QUAL = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_E    = 2'd3;

	// Register reset values.
	localparam logic [11:0] MIN_SEP_RST  = 12'd287;
	localparam logic [8:0]  MAX_IMB_RST  = 9'd77;
	localparam logic [13:0] MAX_QUAL_RST = 14'd768;
	localparam logic [15:0] MIN_E_RST    = 16'd1024;

	// Azimuth wrap: pi and 2*pi in units of 1/4096 rad.
	localparam logic signed [15:0] PI_Q     = 16'sd12868;
	localparam logic signed [15:0] TWO_PI_Q = 16'sd25736;

	// Momentum band edges (units 1/256 GeV).
	localparam logic [12:0] MOM_LO  = 13'd512;
	localparam logic [12:0] MOM_B1  = 13'd768;
	localparam logic [12:0] MOM_B2  = 13'd1024;
	localparam logic [12:0] MOM_HI  = 13'd1280;

	// Charge band edges (units 0.1).
	localparam logic [21:0] CHG_B0 = 22'd213955;
	localparam logic [21:0] CHG_B1 = 22'd536409;
	localparam logic [21:0] CHG_B2 = 22'd1097680;
	localparam logic [21:0] CHG_B3 = 22'd2500000;

	// One input item as packed on the slave tdata, last field lowest.
	typedef struct packed {
		logic [3:0]         pad;
		logic [21:0]        charge_sum;
		logic [12:0]        pair_momentum;
		logic [10:0]        pair_mass;
		logic [13:0]        quality_b;
		logic [13:0]        quality_a;
		logic signed [14:0] phi_b;
		logic signed [14:0] phi_a;
		logic signed [13:0] eta_b;
		logic signed [13:0] eta_a;
		logic [15:0]        energy_b;
		logic [15:0]        energy_a;
	} in_item_t;

endpackage

### hdl/diphoton_cut_and_histogram_core.sv
// Diphoton candidate cuts with a per-class saturating mass histogram.
//
// Usage:
//  - Slave stream s_axis_* takes one two-cluster candidate per item; the
//    master stream m_axis_* returns exactly one result item per candidate,
//    in order. Both transfer on a clock edge with tvalid and tready high.
//  - Cut limits are written through cfg_we / cfg_index / cfg_data while
//    the core is idle; index 0 min separation, 1 max imbalance, 2 max
//    quality, 3 min energy.
//  - Items pass the stage 1, 2, 3 and result registers. One item is taken
//    every cycle while s_axis_tready is high; the histogram memory has one
//    read and one write port, and a read-modify-write of a bin spans three
//    stages with the newer count forwarded to a following same-bin item.
//  - After reset the core sweeps the 972-entry histogram memory to zero,
//    one entry per cycle, so s_axis_tready stays low until the sweep ends.
//    Configuration writes are taken during the sweep.
//  - When the receiver holds m_axis_tready low with a result waiting, the
//    whole pipeline freezes and s_axis_tready drops until it moves again.
module diphoton_cut_and_histogram_core
	import dphist_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	// Configuration write port.
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	// Candidate input.
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	// tdata from bit 0: energy_a, energy_b, eta_a, eta_b, phi_a, phi_b,
	// quality_a, quality_b, pair_mass, pair_momentum, charge_sum, zero pad.
	input  logic [IN_W-1:0]       s_axis_tdata,
	// Result output.
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// tdata from bit 0: accepted, class_index, mass_bin, bin_count, zero pad.
	output logic [OUT_W-1:0]      m_axis_tdata
);

	localparam logic [COUNT_WIDTH-1:0] CMAX = '1;

	// Configuration registers.
	logic [11:0] min_sep_q;
	logic [8:0]  max_imb_q;
	logic [13:0] max_qual_q;
	logic [15:0] min_e_q;

	// Clearing sweep.
	logic              clr_busy_q;
	logic [ADDR_W-1:0] clr_addr_q;

	// Pipeline control and payload.
	logic adv;
	logic v_s1, v_s2, v_s3, out_valid_q;

	logic signed [14:0] deta_s1;
	logic signed [15:0] dphi_s1;
	logic [15:0]        diff_s1;
	logic [16:0]        esum_s1;
	logic               pre_ok_s1;
	logic [CLASS_W-1:0] cls_s1;
	logic [BIN_W-1:0]   bin_s1;
	logic [ADDR_W-1:0]  addr_s1;

	logic [27:0]          deta2_s2;
	logic [29:0]          dphi2_s2;
	logic [23:0]          lim2_s2;
	logic [23:0]          imb_lhs_s2;
	logic [25:0]          imb_rhs_s2;
	logic                 pre_ok_s2;
	logic [CLASS_W-1:0]   cls_s2;
	logic [BIN_W-1:0]     bin_s2;
	logic [ADDR_W-1:0]    addr_s2;
	logic [COUNT_WIDTH-1:0] rd_s2;
	logic                 byp_hit_s2;
	logic [COUNT_WIDTH-1:0] byp_data_s2;

	logic                   acc_s3;
	logic [CLASS_W-1:0]     cls_s3;
	logic [BIN_W-1:0]       bin_s3;
	logic [ADDR_W-1:0]      addr_s3;
	logic [COUNT_WIDTH-1:0] cnt_s3;

	logic                   acc_q;
	logic [CLASS_W-1:0]     cls_q;
	logic [BIN_W-1:0]       bin_q;
	logic [COUNT_WIDTH-1:0] cnt_q;

	// Histogram memory.
	logic [COUNT_WIDTH-1:0] hist_mem [HIST_SIZE];
	logic                   mem_we;
	logic [ADDR_W-1:0]      mem_waddr;
	logic [COUNT_WIDTH-1:0] mem_wdata;

	// Combinational signals.
	in_item_t           in_item;
	logic signed [15:0] dphi_raw, dphi_abs, dphi_wrap;
	logic [15:0]        ediff;
	logic               q_ok, e_ok, mom_ok, chg_ok;
	logic [1:0]         mom_band, chg_band;
	logic [CLASS_W-1:0] cls_c;
	logic [BIN_W-1:0]   bin_c;
	logic signed [29:0] deta_sq;
	logic signed [31:0] dphi_sq;
	logic [30:0]        sep2;
	logic               acc_s2;
	logic               wr_s3;
	logic [COUNT_WIDTH-1:0] old_cnt_s2;
	logic [COUNT_WIDTH-1:0] new_cnt_s3;

	assign adv           = !out_valid_q || m_axis_tready;
	assign s_axis_tready = adv && !clr_busy_q;
	assign in_item       = in_item_t'(s_axis_tdata);

	// Configuration register writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_sep_q  <= MIN_SEP_RST;
			max_imb_q  <= MAX_IMB_RST;
			max_qual_q <= MAX_QUAL_RST;
			min_e_q    <= MIN_E_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MIN_SEP:  min_sep_q  <= cfg_data[11:0];
				REG_MAX_IMB:  max_imb_q  <= cfg_data[8:0];
				REG_MAX_QUAL: max_qual_q <= cfg_data[13:0];
				REG_MIN_E:    min_e_q    <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// Post-reset sweep that zeroes every histogram entry.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == ADDR_W'(HIST_SIZE - 1)) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	// Stage 0: differences, simple cuts, bands, class and mass bin.
	always_comb begin
		dphi_raw = 16'(in_item.phi_a) - 16'(in_item.phi_b);
		dphi_abs = (dphi_raw < 0) ? -dphi_raw : dphi_raw;
		dphi_wrap = (dphi_abs >= PI_Q) ? (TWO_PI_Q - dphi_abs) : dphi_abs;

		ediff = (in_item.energy_a >= in_item.energy_b) ?
			(in_item.energy_a - in_item.energy_b) :
			(in_item.energy_b - in_item.energy_a);

		q_ok = (in_item.quality_a < max_qual_q) && (in_item.quality_b < max_qual_q);
		e_ok = (in_item.energy_a >= min_e_q) && (in_item.energy_b >= min_e_q);

		mom_ok = (in_item.pair_momentum >= MOM_LO) && (in_item.pair_momentum < MOM_HI);
		if (in_item.pair_momentum < MOM_B1) begin
			mom_band = 2'd0;
		end else if (in_item.pair_momentum < MOM_B2) begin
			mom_band = 2'd1;
		end else begin
			mom_band = 2'd2;
		end

		chg_ok = in_item.charge_sum < CHG_B3;
		if (in_item.charge_sum < CHG_B0) begin
			chg_band = 2'd0;
		end else if (in_item.charge_sum < CHG_B1) begin
			chg_band = 2'd1;
		end else if (in_item.charge_sum < CHG_B2) begin
			chg_band = 2'd2;
		end else begin
			chg_band = 2'd3;
		end

		cls_c = CLASS_W'(chg_band) * CLASS_W'(3) + CLASS_W'(mom_band);

		if (in_item.pair_mass[10:4] >= BIN_W'(NUM_BINS)) begin
			bin_c = BIN_W'(NUM_BINS);
		end else begin
			bin_c = in_item.pair_mass[10:4];
		end
	end

	// Stage 1 registers.
	always_ff @(posedge clk) begin
		if (adv) begin
			deta_s1   <= 15'(in_item.eta_a) - 15'(in_item.eta_b);
			dphi_s1   <= dphi_wrap;
			diff_s1   <= ediff;
			esum_s1   <= 17'(in_item.energy_a) + 17'(in_item.energy_b);
			pre_ok_s1 <= q_ok && e_ok && mom_ok && chg_ok &&
				(cls_c < CLASS_W'(NUM_CLASSES));
			cls_s1    <= cls_c;
			bin_s1    <= bin_c;
			addr_s1   <= ADDR_W'(cls_c) * ADDR_W'(NUM_BINS + 1) + ADDR_W'(bin_c);
		end
	end

	// Stage 1 to 2: squares and the imbalance product.
	assign deta_sq = deta_s1 * deta_s1;
	assign dphi_sq = dphi_s1 * dphi_s1;

	always_ff @(posedge clk) begin
		if (adv) begin
			deta2_s2    <= deta_sq[27:0];
			dphi2_s2    <= dphi_sq[29:0];
			lim2_s2     <= 24'(min_sep_q) * 24'(min_sep_q);
			imb_lhs_s2  <= {diff_s1, 8'd0};
			imb_rhs_s2  <= 26'(max_imb_q) * 26'(esum_s1);
			pre_ok_s2   <= pre_ok_s1;
			cls_s2      <= cls_s1;
			bin_s2      <= bin_s1;
			addr_s2     <= addr_s1;
			byp_hit_s2  <= wr_s3 && (addr_s3 == addr_s1);
			byp_data_s2 <= new_cnt_s3;
		end
	end

	// Histogram memory: read at stage 1, write back from stage 3 or the sweep.
	assign wr_s3     = v_s3 && acc_s3;
	assign mem_we    = clr_busy_q || (adv && wr_s3);
	assign mem_waddr = clr_busy_q ? clr_addr_q : addr_s3;
	assign mem_wdata = clr_busy_q ? '0 : new_cnt_s3;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			hist_mem[mem_waddr] <= mem_wdata;
		end
		if (adv) begin
			rd_s2 <= hist_mem[addr_s1];
		end
	end

	// Stage 2: final cut decision and forwarding of newer counts.
	assign sep2   = 31'(deta2_s2) + 31'(dphi2_s2);
	assign acc_s2 = pre_ok_s2 && (sep2 >= 31'(lim2_s2)) &&
		(26'(imb_lhs_s2) < imb_rhs_s2);

	always_comb begin
		if (wr_s3 && (addr_s3 == addr_s2)) begin
			old_cnt_s2 = new_cnt_s3;
		end else if (byp_hit_s2) begin
			old_cnt_s2 = byp_data_s2;
		end else begin
			old_cnt_s2 = rd_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			acc_s3  <= acc_s2;
			cls_s3  <= cls_s2;
			bin_s3  <= bin_s2;
			addr_s3 <= addr_s2;
			cnt_s3  <= old_cnt_s2;
		end
	end

	// Stage 3: saturating increment and result register.
	assign new_cnt_s3 = (cnt_s3 == CMAX) ? cnt_s3 : cnt_s3 + 1'b1;

	always_ff @(posedge clk) begin
		if (adv) begin
			acc_q <= acc_s3;
			cls_q <= acc_s3 ? cls_s3 : NO_CLASS;
			bin_q <= bin_s3;
			cnt_q <= acc_s3 ? new_cnt_s3 : '0;
		end
	end

	// Valid bits of the pipeline.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			v_s1        <= s_axis_tvalid && s_axis_tready;
			v_s2        <= v_s1;
			v_s3        <= v_s2;
			out_valid_q <= v_s3;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = OUT_W'({cnt_q, bin_q, cls_q, acc_q});

	// A pipeline write-back never collides with the clearing sweep.
	a_no_write_in_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy_q |-> !(v_s1 || v_s2 || v_s3))
		else $error("pipeline active during histogram sweep");

	// An accepted result always reports a nonzero count.
	a_acc_count: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && acc_q) |-> (cnt_q != '0))
		else $error("accepted result with zero count");

	// A rejected result reports no class and no count.
	a_rej_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !acc_q) |-> ((cls_q == NO_CLASS) && (cnt_q == '0)))
		else $error("rejected result carries class or count");

	// Back-to-back hits on the same bin pick up the count just written.
	a_forward: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && wr_s3 && v_s2 && (addr_s3 == addr_s2)) |=>
			(cnt_s3 == $past(new_cnt_s3)))
		else $error("same-bin forwarding lost an update");

endmodule

### tb/sv/diphoton_hist_checker.sv
// Checker for the diphoton core: predicts every result item and compares it.
`timescale 1ns / 100ps

module diphoton_hist_checker
	import dphist_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  s_axis_tvalid,
	input  logic                  s_axis_tready,
	// tdata from bit 0: energy_a, energy_b, eta_a, eta_b, phi_a, phi_b,
	// quality_a, quality_b, pair_mass, pair_momentum, charge_sum, zero pad.
	input  in_item_t              s_axis_tdata,
	input  logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// tdata from bit 0: accepted, class_index, mass_bin, bin_count, zero pad.
	input  logic [OUT_W-1:0]      m_axis_tdata,
	output int unsigned           mismatches,
	output int unsigned           pending_results,
	output int unsigned           results_checked,
	output int unsigned           kept_results
);

	// One result item, laid out as on the master tdata.
	typedef struct packed {
		logic [OUT_W-OUT_BITS-1:0] pad;
		logic [COUNT_WIDTH-1:0]    bin_count;
		logic [BIN_W-1:0]          mass_bin;
		logic [CLASS_W-1:0]        class_index;
		logic                      accepted;
	} result_t;

	// Own copy of the cut limits and of the per-class mass histogram.
	logic [11:0]            min_sep;
	logic [8:0]             max_imb;
	logic [13:0]            max_qual;
	logic [15:0]            min_e;
	logic [COUNT_WIDTH-1:0] bin_tally [HIST_SIZE];

	result_t     awaited_results [$];
	int unsigned fails;
	int unsigned checked;
	int unsigned kept;

	// Applies the four cuts, classifies the candidate and bumps its bin.
	function automatic result_t grade_candidate(input in_item_t c);
		int      d_eta;
		int      d_phi;
		int      mom_band;
		int      chg_band;
		int      slot;
		longint  sep_sq;
		longint  gap;
		bit      passed;
		result_t r;

		d_eta = $signed(c.eta_a) - $signed(c.eta_b);
		d_phi = $signed(c.phi_a) - $signed(c.phi_b);
		if (d_phi < 0) d_phi = -d_phi;
		// Wrap past pi; an out-of-range azimuth can leave this negative.
		if (d_phi >= int'(PI_Q)) d_phi = int'(TWO_PI_Q) - d_phi;
		sep_sq = longint'(d_eta) * d_eta + longint'(d_phi) * d_phi;
		gap = (c.energy_a >= c.energy_b) ? c.energy_a - c.energy_b
			: c.energy_b - c.energy_a;

		passed = sep_sq >= longint'(min_sep) * min_sep
			&& gap * 256 < longint'(max_imb) * (c.energy_a + c.energy_b)
			&& c.quality_a < max_qual && c.quality_b < max_qual
			&& c.energy_a >= min_e && c.energy_b >= min_e;

		if (c.pair_momentum < MOM_LO || c.pair_momentum >= MOM_HI) mom_band = -1;
		else if (c.pair_momentum < MOM_B1) mom_band = 0;
		else if (c.pair_momentum < MOM_B2) mom_band = 1;
		else mom_band = 2;

		if (c.charge_sum < CHG_B0) chg_band = 0;
		else if (c.charge_sum < CHG_B1) chg_band = 1;
		else if (c.charge_sum < CHG_B2) chg_band = 2;
		else if (c.charge_sum < CHG_B3) chg_band = 3;
		else chg_band = -1;

		r = '0;
		r.class_index = NO_CLASS;
		r.mass_bin = BIN_W'(((c.pair_mass >> 4) >= NUM_BINS) ? NUM_BINS : (c.pair_mass >> 4));

		if (passed && mom_band >= 0 && chg_band >= 0
				&& chg_band * 3 + mom_band < NUM_CLASSES) begin
			slot = (chg_band * 3 + mom_band) * (NUM_BINS + 1) + r.mass_bin;
			// A full counter stays where it is.
			if (bin_tally[slot] != '1) bin_tally[slot]++;
			r.accepted = 1'b1;
			r.class_index = CLASS_W'(chg_band * 3 + mom_band);
			r.bin_count = bin_tally[slot];
		end
		return r;
	endfunction

	task automatic compare_field(input string what, input logic [63:0] want,
			input logic [63:0] got);
		if (got !== want) begin
			fails++;
			$display("%0t: %s mismatch, expected %0d, actual %0d",
				$time, what, want, got);
		end
	endtask

	// Watch the three ports; results are checked before new items are predicted.
	always @(posedge clk or negedge arst_n) begin
		result_t want;
		result_t got;

		if (!arst_n) begin
			min_sep  = MIN_SEP_RST;
			max_imb  = MAX_IMB_RST;
			max_qual = MAX_QUAL_RST;
			min_e    = MIN_E_RST;
			for (int i = 0; i < HIST_SIZE; i++) bin_tally[i] = '0;
			awaited_results.delete();
			fails   = 0;
			checked = 0;
			kept    = 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got = m_axis_tdata;
				if (awaited_results.size() == 0) begin
					fails++;
					$display("%0t: result item with none expected, expected none, actual %h",
						$time, got);
				end else begin
					want = awaited_results.pop_front();
					checked++;
					if (want.accepted) kept++;
					compare_field("accepted", 64'(want.accepted), 64'(got.accepted));
					compare_field("class_index", 64'(want.class_index),
						64'(got.class_index));
					compare_field("mass_bin", 64'(want.mass_bin), 64'(got.mass_bin));
					compare_field("bin_count", 64'(want.bin_count), 64'(got.bin_count));
					compare_field("pad", 64'(want.pad), 64'(got.pad));
				end
			end

			if (s_axis_tvalid && s_axis_tready)
				awaited_results.push_back(grade_candidate(s_axis_tdata));

			if (cfg_we) begin
				case (cfg_index)
					REG_MIN_SEP:  min_sep  = cfg_data[11:0];
					REG_MAX_IMB:  max_imb  = cfg_data[8:0];
					REG_MAX_QUAL: max_qual = cfg_data[13:0];
					REG_MIN_E:    min_e    = cfg_data[15:0];
					default: ;
				endcase
			end
		end

		mismatches      <= fails;
		pending_results <= awaited_results.size();
		results_checked <= checked;
		kept_results    <= kept;
	end

endmodule

### tb/sv/diphoton_cut_and_histogram_core_tb.sv
// Top of the diphoton core testbench: clock, reset, limits, candidates and verdict.
`timescale 1ns / 100ps

module diphoton_cut_and_histogram_core_tb
	import dphist_pkg::*;
();

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	in_item_t              s_axis_tdata;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	logic [OUT_W-1:0]      m_axis_tdata;

	int unsigned mismatches;
	int unsigned pending_results;
	int unsigned results_checked;
	int unsigned kept_results;

	// Limits currently written, used only to shape the candidates.
	int unsigned lim_sep;
	int unsigned lim_imb;
	int unsigned lim_qual;
	int unsigned lim_emin;
	int unsigned settings_used;
	in_item_t    last_clean;
	bit          steady;
	bit          hold_req;

	diphoton_cut_and_histogram_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	diphoton_hist_checker hist_check (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.s_axis_tvalid   (s_axis_tvalid),
		.s_axis_tready   (s_axis_tready),
		.s_axis_tdata    (s_axis_tdata),
		.m_axis_tvalid   (m_axis_tvalid),
		.m_axis_tready   (m_axis_tready),
		.m_axis_tdata    (m_axis_tdata),
		.mismatches      (mismatches),
		.pending_results (pending_results),
		.results_checked (results_checked),
		.kept_results    (kept_results)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Candidate aimed to pass the current cuts, mostly inside a class.
	function automatic in_item_t clean_candidate();
		in_item_t    c;
		int unsigned ea;
		int unsigned eb;
		int unsigned spread;
		int          eta_a;
		int          off;
		int          bin;

		c = '0;
		if ($urandom_range(0, 1)) ea = $urandom_range(65535, lim_emin);
		else ea = lim_emin + $urandom_range(0, 255);
		if (ea > 65535) ea = 65535;
		spread = (ea * lim_imb) >> 9;
		eb = ea - $urandom_range(0, spread);
		if (eb < lim_emin) eb = ea;
		if ($urandom_range(0, 1)) begin
			c.energy_a = 16'(ea);
			c.energy_b = 16'(eb);
		end else begin
			c.energy_a = 16'(eb);
			c.energy_b = 16'(ea);
		end
		c.quality_a = 14'((lim_qual == 0) ? $urandom_range(0, 15)
			: $urandom_range(0, lim_qual - 1));
		c.quality_b = 14'((lim_qual == 0) ? $urandom_range(0, 15)
			: $urandom_range(0, lim_qual - 1));

		// Separation is carried by the eta difference.
		eta_a = int'($urandom_range(0, 4000)) - 2000;
		off = lim_sep + $urandom_range(0, 2000);
		if ($urandom_range(0, 1)) off = -off;
		c.eta_a = 14'(eta_a);
		c.eta_b = 14'(eta_a - off);
		c.phi_a = 15'(int'($urandom_range(0, 25736)) - 12868);
		c.phi_b = 15'(int'($urandom_range(0, 25736)) - 12868);

		// Repeat the last bin and class now and then so counts build up back to back.
		if ($urandom_range(0, 9) < 3) begin
			c.pair_mass     = last_clean.pair_mass;
			c.pair_momentum = last_clean.pair_momentum;
			c.charge_sum    = last_clean.charge_sum;
		end else begin
			case ($urandom_range(0, 4))
				0: bin = 3;
				1: bin = 17;
				2: bin = 42;
				3: bin = 79;
				default: bin = 80;
			endcase
			if ($urandom_range(0, 9) < 7) c.pair_mass = 11'(bin * 16 + $urandom_range(0, 15));
			else c.pair_mass = 11'($urandom);
			c.pair_momentum = 13'(($urandom_range(0, 9) == 0) ? $urandom
				: $urandom_range(512, 1279));
			c.charge_sum = 22'(($urandom_range(0, 9) == 0) ? $urandom
				: $urandom_range(0, 2499999));
		end
		last_clean = c;
		return c;
	endfunction

	// Clean candidate with one field disturbed, most often pushing a cut onto or past its limit.
	function automatic in_item_t broken_candidate();
		in_item_t c;

		c = clean_candidate();
		case ($urandom_range(0, 5))
			0: c.quality_a = 14'(lim_qual);
			1: c.energy_b = 16'(lim_emin - 1);
			2: begin
				c.eta_b = c.eta_a;
				c.phi_b = 15'(c.phi_a + $urandom_range(0, 300));
			end
			3: c.energy_b = c.energy_a >> 2;
			4: c.phi_b = 15'($urandom);
			default: begin
				c.eta_b = 14'(c.eta_a - lim_sep);
				c.phi_b = c.phi_a;
			end
		endcase
		return c;
	endfunction

	function automatic in_item_t mixed_candidate();
		in_item_t    c;
		int unsigned pick;

		pick = $urandom_range(0, 9);
		if (pick < 6) c = clean_candidate();
		else if (pick < 8) c = broken_candidate();
		else begin
			c = IN_W'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
			c.pad = '0;
		end
		return c;
	endfunction

	// Offers one item, after a random gap unless steady, and waits for its handshake.
	task automatic push_candidate(input in_item_t c);
		@(negedge clk);
		while (!steady && $urandom_range(0, 99) < 35) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= c;
		do @(posedge clk); while (!s_axis_tready);
	endtask

	task automatic write_limit(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val[15:0];
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Limits change only once every outstanding result has come back.
	task automatic set_limits(input int unsigned sep, imb, qual, emin);
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (pending_results != 0) @(posedge clk);
		write_limit(REG_MIN_SEP, sep);
		write_limit(REG_MAX_IMB, imb);
		write_limit(REG_MAX_QUAL, qual);
		write_limit(REG_MIN_E, emin);
		lim_sep  = sep;
		lim_imb  = imb;
		lim_qual = qual;
		lim_emin = emin;
		settings_used++;
	endtask

	task automatic stream_random(input int count, input int steady_items, input int hold_at);
		for (int i = 0; i < count; i++) begin
			steady = (i < steady_items);
			if (i == hold_at) hold_req = 1'b1;
			push_candidate(mixed_candidate());
		end
		steady = 1'b0;
	endtask

	// Result side: random stalls, plus one long hold-off on request.
	initial begin
		int held;

		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				m_axis_tready <= 1'b0;
				for (held = 0; held < 400; held++) @(negedge clk);
				hold_req = 1'b0;
			end
			m_axis_tready <= steady || ($urandom_range(0, 99) >= 35);
		end
	end

	// Stimulus and verdict.
	initial begin
		in_item_t base;
		in_item_t d;

		arst_n        = 1'b0;
		cfg_we        = 1'b0;
		cfg_index     = '0;
		cfg_data      = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		steady        = 1'b0;
		hold_req      = 1'b0;
		settings_used = 0;
		last_clean    = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset limits, written while the core is still clearing its histogram.
		set_limits(32'(MIN_SEP_RST), 32'(MAX_IMB_RST), 32'(MAX_QUAL_RST), 32'(MIN_E_RST));

		// Candidate sitting exactly on the separation, quality, energy and low momentum limits.
		base = '0;
		base.energy_a  = 16'd1024;
		base.energy_b  = 16'd1024;
		base.eta_a     = 14'(287);
		base.quality_a = 14'd767;
		base.quality_b = 14'd767;
		base.pair_momentum = MOM_LO;
		push_candidate(base);
		push_candidate(base);
		// Both energies zero fail the imbalance test.
		push_candidate('0);
		d = '1;
		d.pad = '0;
		push_candidate(d);
		d = base; d.quality_b = 14'd768; push_candidate(d);
		d = base; d.energy_a = 16'd1023; push_candidate(d);
		d = base; d.eta_a = 14'(286); push_candidate(d);
		// Energy imbalance exactly at the limit, then just inside it.
		d = base; d.energy_a = 16'd3330; d.energy_b = 16'd1790; push_candidate(d);
		d.energy_a = 16'd3329; d.energy_b = 16'd1791; push_candidate(d);
		// Azimuth difference of two pi wraps to zero.
		d = base; d.eta_a = '0; d.phi_a = 15'(12868); d.phi_b = 15'(-12868);
		push_candidate(d);
		// Azimuth beyond the valid range wraps to a negative difference.
		d = base; d.eta_a = '0; d.phi_a = 15'(16383); d.phi_b = 15'(-16384);
		push_candidate(d);
		d = base; d.eta_a = 14'(-8192); d.eta_b = 14'(8191); push_candidate(d);
		// Momentum band edges.
		d = base; d.pair_momentum = MOM_LO - 13'd1; push_candidate(d);
		d = base; d.pair_momentum = MOM_B1; push_candidate(d);
		d = base; d.pair_momentum = MOM_HI - 13'd1; push_candidate(d);
		d = base; d.pair_momentum = MOM_HI; push_candidate(d);
		// Charge band edges, with the mass at the overflow edges.
		d = base; d.charge_sum = CHG_B0; d.pair_mass = 11'd1279; push_candidate(d);
		d = base; d.charge_sum = CHG_B2 - 22'd1; d.pair_mass = 11'd1280; push_candidate(d);
		d = base; d.charge_sum = CHG_B3 - 22'd1; d.pair_mass = 11'd2047; push_candidate(d);
		d = base; d.charge_sum = CHG_B3; push_candidate(d);
		d = base; d.charge_sum = 22'h3FFFFF; push_candidate(d);

		stream_random(200, 0, -1);

		// Loosest and tightest limits.
		set_limits(0, 256, 16383, 1);
		stream_random(250, 0, -1);
		set_limits(4095, 0, 0, 65535);
		stream_random(100, 0, -1);

		// Random limits; one phase runs without idling, another holds off the output.
		for (int ph = 0; ph < 4; ph++) begin
			set_limits($urandom_range(0, 4095), $urandom_range(1, 256),
				$urandom_range(1, 16383), $urandom_range(1, 65535));
			stream_random(240, (ph == 0) ? 150 : 0, (ph == 1) ? 50 : -1);
		end

		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (pending_results != 0) @(posedge clk);
		repeat (20) @(posedge clk);

		$display("Checked %0d results, %0d kept into the histogram, under %0d limit settings.",
			results_checked, kept_results, settings_used);
		$display("Covered band and limit edges, azimuth wrap, repeated bins and a long stall.");
		if (mismatches == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

	// Watchdog.
	initial begin
		#2_000_000;
		$display("Timeout with %0d results outstanding.", pending_results);
		$display("*** FAILED ***");
		$finish;
	end

endmodule

### diphoton_cut_and_histogram_core.f
hdl/dphist_pkg.sv
hdl/diphoton_cut_and_histogram_core.sv
tb/sv/diphoton_hist_checker.sv
tb/sv/diphoton_cut_and_histogram_core_tb.sv
